// ----- rtl/sfe_pkg.sv -----
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants for the SBUS frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int unsigned SLOT_COUNT = 16;
  localparam logic [7:0]  HEADER_BYTE = 8'h0F;
  localparam logic [15:0] MIN_US = 16'd880;
  // Widths at or above this value saturate: (2160 - 880) * 8 / 5 = 2048.
  localparam logic [15:0] SAT_US = 16'd2160;
  localparam logic [10:0] MAX_VALUE = 11'h7FF;
  // ceil(2^18 / 5); exact divide by five for dividends below 2^18.
  localparam logic [15:0] RECIP_5 = 16'd52429;
  localparam int unsigned FLAG_FAILSAFE_BIT = 3;

  // Register indexes on the configuration port.
  localparam logic REG_CHANNELS_USED = 1'b0;
  localparam logic REG_CENTER_WIDTH  = 1'b1;

  localparam logic [4:0]  CHANNELS_RESET = 5'd16;
  localparam logic [15:0] CENTER_RESET   = 16'd1500;

  typedef struct packed {
    logic [15:0] pulse_us;
    logic        failsafe;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_t;

  // Converted channel value waiting to be packed.
  typedef struct packed {
    logic [10:0] value;
    logic        failsafe;
  } slot_t;

  // Frame settings derived from the configuration registers.
  typedef struct packed {
    logic [4:0]  limit;
    logic [10:0] pad_value;
  } frame_cfg_t;

endpackage

// ----- rtl/sfe_convert.sv -----
// ----------------------------------------------------------------------------
// sfe_convert
// Pulse width in microseconds to 11-bit channel value.
// ----------------------------------------------------------------------------
module sfe_convert import sfe_pkg::*; (
  input  logic [15:0] pulse_us,
  output logic [10:0] value
);

  logic [15:0] offset;
  logic [13:0] scaled;
  logic [29:0] product;

  // Only offsets below 1280 reach the divide, so eight times the offset
  // fits 14 bits.
  assign offset  = pulse_us - MIN_US;
  assign scaled  = {offset[10:0], 3'b000};
  assign product = {16'b0, scaled} * {14'b0, RECIP_5};

  always_comb begin
    if (pulse_us < MIN_US) begin
      value = '0;
    end else if (pulse_us >= SAT_US) begin
      value = MAX_VALUE;
    end else begin
      value = product[28:18];
    end
  end

endmodule

// ----- rtl/sfe_packer.sv -----
// ----------------------------------------------------------------------------
// sfe_packer
// Bit packer and frame sequencer; drives the byte output register.
// ----------------------------------------------------------------------------
module sfe_packer import sfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  frame_cfg_t cfg,
  input  logic       slot_valid,
  input  slot_t      slot,
  output logic       slot_take,
  output logic       frame_valid,
  input  logic       frame_ready,
  output frame_t     frame
);

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_RUN,
    ST_PAD,
    ST_FLAGS,
    ST_END
  } state_t;

  state_t      state;
  logic [17:0] acc;
  logic [4:0]  held;
  logic [4:0]  channel;
  logic        failsafe;

  logic        can_emit;
  logic        have_byte;
  logic        frame_load;
  logic [10:0] pack_value;
  logic [17:0] acc_packed;
  logic [4:0]  channel_next;

  assign can_emit  = !frame_valid || frame_ready;
  assign have_byte = held >= 5'd8;

  assign pack_value   = (state == ST_PAD) ? cfg.pad_value : slot.value;
  assign acc_packed   = acc | ({7'b0, pack_value} << held[2:0]);
  assign channel_next = channel + 5'd1;

  // Take the waiting slot only when it is packed.
  assign slot_take = (state == ST_RUN) && !have_byte && slot_valid;

  // Load the output register whenever the sequencer sends a byte.
  always_comb begin
    frame_load = 1'b0;
    if (can_emit) begin
      unique case (state)
        ST_HEADER:        frame_load = slot_valid;
        ST_RUN, ST_PAD:   frame_load = have_byte;
        ST_FLAGS, ST_END: frame_load = 1'b1;
        default:          frame_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_HEADER;
      acc         <= '0;
      held        <= '0;
      channel     <= '0;
      failsafe    <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      frame_valid <= frame_load || (frame_valid && !frame_ready);
      unique case (state)
        ST_HEADER: begin
          if (slot_valid && can_emit) begin
            frame.frame_byte <= HEADER_BYTE;
            frame.last_byte  <= 1'b0;
            state            <= ST_RUN;
          end
        end
        ST_RUN, ST_PAD: begin
          if (have_byte) begin
            if (can_emit) begin
              frame.frame_byte <= acc[7:0];
              frame.last_byte  <= 1'b0;
              acc              <= acc >> 8;
              held             <= held - 5'd8;
            end
          end else if (state == ST_PAD) begin
            if (channel < 5'(SLOT_COUNT)) begin
              acc     <= acc_packed;
              held    <= {2'b0, held[2:0]} + 5'd11;
              channel <= channel_next;
            end else begin
              state <= ST_FLAGS;
            end
          end else if (slot_valid) begin
            acc     <= acc_packed;
            held    <= {2'b0, held[2:0]} + 5'd11;
            channel <= channel_next;
            // Final supplied channel: latch its flag and pad the rest.
            if (channel_next >= cfg.limit) begin
              failsafe <= slot.failsafe;
              state    <= ST_PAD;
            end
          end
        end
        ST_FLAGS: begin
          if (can_emit) begin
            frame.frame_byte <= 8'({failsafe, 3'b000});
            frame.last_byte  <= 1'b0;
            state            <= ST_END;
          end
        end
        ST_END: begin
          if (can_emit) begin
            frame.frame_byte <= 8'h00;
            frame.last_byte  <= 1'b1;
            acc              <= '0;
            held             <= '0;
            channel          <= '0;
            state            <= ST_HEADER;
          end
        end
        default: begin
          state <= ST_HEADER;
        end
      endcase
    end
  end

endmodule

// ----- rtl/sbus_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// sbus_frame_encoder
// Builds 25-byte SBUS frames from channel pulse widths, one channel per request.
// ----------------------------------------------------------------------------
// Each request on the item channel carries one channel pulse width. The width
// is converted to an 11-bit value on entry and held in a one-deep slot; the
// packer folds it into an 18-bit bit accumulator and sends completed bytes,
// least significant bit first, through a single output register at one byte
// per cycle while the output is not stalled. A frame opens with header 0x0F
// when its first channel arrives. After the last supplied channel (channels_used,
// clamped to 1..16) the packer fills the remaining slots with the converted
// center width, then sends the flags byte (bit 3 = failsafe of the last
// supplied channel) and a zero end byte marked by last_byte. Each channel is
// first packed into the accumulator, then every byte it completes is sent;
// the first channel is preceded by the header, and the last one is followed
// by the padded channels and their bytes, the close of the padding and the
// flags and end bytes. Packing and byte output alternate, so the packer sets
// the pace. The slot accepts a new request while the packer still drains
// earlier bytes.
// Registers: 0x0 channels_used (5 bits), 0x4 center_width_us (16 bits); write
// them only between frames.
module sbus_frame_encoder import sfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // channel widths
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  // frame bytes
  output logic        frame_valid,
  input  logic        frame_ready,
  output frame_t      frame
);

  logic [4:0]  channels_used;
  logic [15:0] center_width_us;
  logic [10:0] pad_value;
  frame_cfg_t  cfg;

  logic        slot_valid;
  slot_t       slot;
  logic        slot_take;
  logic [10:0] item_value;
  logic [10:0] center_value;

  // Configuration registers; pready stays high, so a write lands on access.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_used   <= CHANNELS_RESET;
      center_width_us <= CENTER_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_CHANNELS_USED: channels_used   <= pwdata[4:0];
        REG_CENTER_WIDTH:  center_width_us <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CHANNELS_USED: prdata = {27'b0, channels_used};
      REG_CENTER_WIDTH:  prdata = {16'b0, center_width_us};
      default:           prdata = '0;
    endcase
  end

  // Register the converted pad value to keep the converter off the packer path.
  sfe_convert u_center_convert (
    .pulse_us (center_width_us),
    .value    (center_value)
  );

  always_ff @(posedge clk) begin
    pad_value <= center_value;
  end

  // Clamp the channel count: zero acts as one, above sixteen as sixteen.
  always_comb begin
    cfg.pad_value = pad_value;
    if (channels_used == 5'd0) begin
      cfg.limit = 5'd1;
    end else if (channels_used > 5'(SLOT_COUNT)) begin
      cfg.limit = 5'(SLOT_COUNT);
    end else begin
      cfg.limit = channels_used;
    end
  end

  // Convert on entry and hold the value in the slot until packed.
  sfe_convert u_item_convert (
    .pulse_us (item.pulse_us),
    .value    (item_value)
  );

  assign item_ready = !slot_valid || slot_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (item_ready) begin
      slot_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      slot.value    <= item_value;
      slot.failsafe <= item.failsafe;
    end
  end

  sfe_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .slot_valid  (slot_valid),
    .slot        (slot),
    .slot_take   (slot_take),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

endmodule

// ----- bench/sbus_frame_encoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbus_frame_encoder_tb
// Self-checking bench for the SBUS frame encoder.
// ----------------------------------------------------------------------------
// Channel widths go in one request at a time. A behavioral copy of the packer
// works out every frame byte that each request should produce. The bytes are
// queued, and each byte that leaves the block is compared against the queue.
// The run covers directed width boundaries, clamped channel counts and a count
// lowered mid-frame. Random frames follow under three idling patterns, with
// the registers rewritten between frames and now and then mid-frame.
// ----------------------------------------------------------------------------
module sbus_frame_encoder_tb;
  import sfe_pkg::*;

  // Byte addresses of the two registers: index times four.
  localparam logic [2:0] CHANNELS_ADDR = {REG_CHANNELS_USED, 2'b00};
  localparam logic [2:0] CENTER_ADDR   = {REG_CENTER_WIDTH, 2'b00};
  // Quiet cycles after the last expected byte.
  localparam int unsigned SETTLE_CYCLES = 30;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        frame_valid;
  logic        frame_ready;
  frame_t      frame;

  // Idle and stall odds, in percent per cycle.
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned error_count;

  // Predictor copy of the registers and the packer state.
  logic [4:0]  channels_cfg;
  logic [15:0] center_cfg;
  logic [17:0] pending_bits;
  logic [4:0]  pending_count;
  logic [4:0]  channels_packed;
  logic        header_done;

  // Frame bytes still owed by the block, oldest first.
  frame_t frame_bytes_due[$];

  int unsigned boundary_us[10] = '{0, 879, 880, 881, 882, 885, 2159, 2160, 2161, 65535};

  sbus_frame_encoder uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: drop ready at random, per the current stall odds.
  always @(negedge clk) begin
    frame_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_frame();
    pending_bits    = '0;
    pending_count   = '0;
    channels_packed = '0;
    header_done     = 1'b0;
  endfunction

  function automatic void owe_byte(input logic [7:0] value, input logic last);
    frame_t want;
    want.frame_byte = value;
    want.last_byte  = last;
    frame_bytes_due.push_back(want);
  endfunction

  // Microseconds to the 11-bit channel code, saturating at the top.
  function automatic logic [10:0] width_to_code(input logic [15:0] us);
    int unsigned scaled;
    if (us < MIN_US) return '0;
    scaled = ((32'(us) - 32'(MIN_US)) * 8) / 5;
    if (scaled > 32'(MAX_VALUE)) return MAX_VALUE;
    return scaled[10:0];
  endfunction

  // Append one code LSB first and owe every byte it completes.
  function automatic void pack_code(input logic [10:0] code);
    logic [31:0] wide;
    int unsigned bits;
    wide = 32'(pending_bits) | (32'(code) << pending_count[2:0]);
    bits = 32'(pending_count[2:0]) + 11;
    while (bits >= 8) begin
      owe_byte(wide[7:0], 1'b0);
      wide = wide >> 8;
      bits = bits - 8;
    end
    pending_bits    = wide[17:0];
    pending_count   = bits[4:0];
    channels_packed = channels_packed + 1'b1;
  endfunction

  // Work out all bytes that one accepted channel request produces.
  function automatic void predict_frame_bytes(input item_t req);
    int unsigned limit;
    logic [7:0]  flags;
    if (channels_cfg == 0) limit = 1;
    else if (channels_cfg > SLOT_COUNT) limit = SLOT_COUNT;
    else limit = channels_cfg;
    if (!header_done) begin
      owe_byte(HEADER_BYTE, 1'b0);
      header_done = 1'b1;
    end
    pack_code(width_to_code(req.pulse_us));
    // Last supplied channel: pad with the center width, then close the frame.
    if (channels_packed >= limit) begin
      while (channels_packed < SLOT_COUNT) pack_code(width_to_code(center_cfg));
      flags = '0;
      flags[FLAG_FAILSAFE_BIT] = req.failsafe;
      owe_byte(flags, 1'b0);
      owe_byte(8'h00, 1'b1);
      clear_frame();
    end
  endfunction

  // ----------------------------------------------------------------- checker

  // Compare every byte that leaves the block with the oldest one owed.
  always @(posedge clk) begin : check_frame_bytes
    frame_t want;
    if (!rst && frame_valid && frame_ready) begin
      if (frame_bytes_due.size() == 0) begin
        $error("frame byte %02h with none expected", frame.frame_byte);
        error_count++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame.frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %02h, got %02h", want.frame_byte, frame.frame_byte);
          error_count++;
        end
        if (frame.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, frame.last_byte);
          error_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------ bus helpers

  // Send one channel request; hold valid and payload until it is taken.
  task automatic send_channel(input logic [15:0] us, input logic fs);
    item_t req;
    req.pulse_us = us;
    req.failsafe = fs;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item       = req;
    do @(posedge clk); while (!item_ready);
    predict_frame_bytes(req);
  endtask

  // Hold off new requests until every owed byte is out, then let it settle.
  task automatic wait_frame_drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands on the edge with pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == CHANNELS_ADDR) channels_cfg = data[4:0];
    else if (addr == CENTER_ADDR) center_cfg = data[15:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic logic [15:0] random_width();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'(boundary_us[$urandom_range(0, 9)]);
      default: return 16'($urandom_range(880, 2160));
    endcase
  endfunction

  // Drain, then rewrite both registers. Upper data bits carry noise.
  task automatic reconfigure_random();
    logic [31:0] noise;
    logic [4:0]  count;
    logic [15:0] center;
    case ($urandom_range(0, 19))
      0:       count = 5'd0;
      1:       count = 5'($urandom_range(17, 31));
      2:       count = 5'd16;
      3:       count = 5'd1;
      default: count = 5'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 9))
      0:       center = 16'd0;
      1:       center = 16'hFFFF;
      2:       center = 16'd879;
      3:       center = 16'd2160;
      default: center = 16'($urandom_range(880, 2160));
    endcase
    wait_frame_drain();
    noise = $urandom;
    write_reg(CHANNELS_ADDR, {noise[31:5], count});
    noise = $urandom;
    write_reg(CENTER_ADDR, {noise[31:16], center});
  endtask

  task automatic set_pace(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // ------------------------------------------------------------------- tests

  // One full frame with the count above sixteen (acts as sixteen); walk the
  // width boundaries: below minimum, exact steps, saturation, full scale.
  task automatic test_width_boundaries();
    logic [15:0] widths [16] = '{0, 879, 880, 881, 882, 883, 884, 885,
                                 1500, 2000, 2159, 2160, 2161, 40000, 65535, 1234};
    wait_frame_drain();
    write_reg(CHANNELS_ADDR, 32'd31);
    write_reg(CENTER_ADDR, 32'd1500);
    // Failsafe toggles on earlier channels; only the last one counts.
    for (int i = 0; i < 16; i++) send_channel(widths[i], (i == 15) ? 1'b1 : i[0]);
  endtask

  // Single-channel frames: count one, then count zero (acts as one), with the
  // center width at both ends of its range.
  task automatic test_short_frames();
    wait_frame_drain();
    write_reg(CHANNELS_ADDR, 32'd1);
    write_reg(CENTER_ADDR, 32'd0);
    send_channel(16'hFFFF, 1'b1);
    wait_frame_drain();
    write_reg(CHANNELS_ADDR, 32'd0);
    write_reg(CENTER_ADDR, 32'hFFFF);
    send_channel(16'd880, 1'b0);
  endtask

  // Lower the count below the channels already packed; the next channel
  // closes the frame. Early failsafe flags must not leak into the flags byte.
  task automatic test_count_lowered_midframe();
    wait_frame_drain();
    write_reg(CHANNELS_ADDR, 32'd16);
    write_reg(CENTER_ADDR, 32'd2160);
    for (int i = 0; i < 4; i++) send_channel(random_width(), 1'b1);
    wait_frame_drain();
    write_reg(CHANNELS_ADDR, 32'd2);
    send_channel(16'd1700, 1'b0);
  endtask

  // Random frames; retune mostly between frames, rarely in the middle.
  task automatic test_random_frames(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (!header_done && $urandom_range(0, 3) == 0) reconfigure_random();
      else if (header_done && $urandom_range(0, 39) == 0) reconfigure_random();
      send_channel(random_width(), 1'($urandom_range(0, 1)));
    end
  endtask

  // ------------------------------------------------------------------- main

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    item_valid   = 1'b0;
    item         = '0;
    frame_ready  = 1'b0;
    error_count  = 0;
    channels_cfg = CHANNELS_RESET;
    center_cfg   = CENTER_RESET;
    clear_frame();
    set_pace(15, 69);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_width_boundaries();
    test_short_frames();
    test_count_lowered_midframe();
    reconfigure_random();
    test_random_frames(96);
    set_pace(69, 15);
    test_random_frames(96);
    set_pace(0, 0);
    test_random_frames(97);

    wait_frame_drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sfe_pkg.sv
rtl/sfe_convert.sv
rtl/sfe_packer.sv
rtl/sbus_frame_encoder.sv
bench/sbus_frame_encoder_tb.sv
